### hdl/bsas_pkg.sv
package bsas_pkg;

  localparam int DEF_MAX_BLOCKS = 64;
  localparam int DEF_MASK_BITS  = 64;
  localparam int DEF_INDEX_BITS = 20;

  localparam logic [1:0] ACT_GET = 2'd0;
  localparam logic [1:0] ACT_SET = 2'd1;
  localparam logic [1:0] ACT_DEL = 2'd2;

  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_ABSENT = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;

  typedef enum logic [4:0] {
    S_IDLE,
    S_SR_RD,
    S_SR_CHK,
    S_DISPATCH,
    S_GET_RD,
    S_GET_WT,
    S_ALLOC,
    S_ALLOC_WT,
    S_TUP_CHK,
    S_TUP_WR,
    S_SET,
    S_VUP_CHK,
    S_VUP_WR,
    S_DEL,
    S_TDN_CHK,
    S_TDN_WR,
    S_VDN_CHK,
    S_VDN_WR,
    S_FIN
  } state_t;

endpackage

### hdl/bitmap_sparse_array_store_top.sv
// sparse integer array store, kept as a sorted table of blocks
// input channel (in_valid/in_ready): one request with action (get, set,
// delete), index and value_in. output channel (out_valid/out_ready): one
// result per request with status and value_out.
// a request is taken only while the sequencer is idle. it first walks the
// block table one block at a time, then shifts table entries or packed
// values one at a time through single-port-read memories, each moved
// entry taking a read and then a write.
// values of a block live in a page of the value memory; pages are handed
// out from a free stack, so creating or removing a block shifts only the
// block table, never the values.
// reset empties the table and the page pool at once; memory contents are
// not cleared.
// the result sits in an output register: the next request may be taken
// while it waits, but a new result is held back until the old one is taken.
module bitmap_sparse_array_store_top
  import bsas_pkg::*;
#(
  parameter int MAX_BLOCKS = DEF_MAX_BLOCKS,
  parameter int MASK_BITS  = DEF_MASK_BITS,
  parameter int INDEX_BITS = DEF_INDEX_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         action,
  input  logic [19:0]        index,
  input  logic signed [31:0] value_in,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         status,
  output logic signed [31:0] value_out
);

  localparam int KEY_W = $clog2(((64'(1) << INDEX_BITS) - 1) / MASK_BITS + 1);
  localparam int SL_W  = $clog2(MASK_BITS);
  localparam int PC_W  = $clog2(MASK_BITS + 1);
  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
  localparam int TI_W  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int TW    = KEY_W + MASK_BITS + TI_W;
  localparam int VD    = MAX_BLOCKS * MASK_BITS;
  localparam int VA_W  = $clog2(VD);

  state_t state, state_next;

  logic [1:0]           act;
  logic [KEY_W-1:0]     key;
  logic [SL_W-1:0]      bitn;
  logic [31:0]          val;
  logic [31:0]          rval;
  logic [CNT_W-1:0]     pos, j, count, fresh, free_top;
  logic [PC_W-1:0]      k, slot, cnt;
  logic                 hit;
  logic [MASK_BITS-1:0] pres;
  logic [TI_W-1:0]      page;
  logic [1:0]           st;

  logic [INDEX_BITS-1:0] idx;
  logic [KEY_W-1:0]      in_key;
  logic [SL_W-1:0]       in_bit;
  logic [MASK_BITS-1:0]  bm, below;

  logic            t_we;
  logic [TI_W-1:0] t_waddr, t_raddr;
  logic [TW-1:0]   t_wdata, t_rdata;
  logic [KEY_W-1:0]     t_base;
  logic [MASK_BITS-1:0] t_pres;
  logic [TI_W-1:0]      t_page;

  logic            v_we;
  logic [VA_W-1:0] v_waddr, v_raddr;
  logic [31:0]     v_wdata, v_rdata;

  logic            s_we;
  logic [TI_W-1:0] s_waddr, s_raddr;
  logic [TI_W-1:0] s_wdata, s_rdata;

  logic [MASK_BITS-1:0] pc_in;
  logic [PC_W-1:0]      pc_out;

  logic accept, out_free, present;

  function automatic logic [VA_W-1:0] va(input logic [TI_W-1:0] pg,
                                         input logic [PC_W-1:0] off);
    return VA_W'(VA_W'(pg) * VA_W'(MASK_BITS) + VA_W'(off));
  endfunction

  assign idx    = INDEX_BITS'(index);
  assign in_key = KEY_W'(idx / MASK_BITS);
  assign in_bit = SL_W'(idx % MASK_BITS);
  assign bm     = MASK_BITS'(1) << bitn;
  assign below  = ~({MASK_BITS{1'b1}} << bitn);

  assign t_base = t_rdata[TW-1 -: KEY_W];
  assign t_pres = t_rdata[TI_W +: MASK_BITS];
  assign t_page = t_rdata[TI_W-1:0];

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign present  = hit && pres[bitn];

  bsas_ram #(.W(TW), .D(MAX_BLOCKS)) u_tbl (
    .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
    .raddr(t_raddr), .rdata(t_rdata)
  );

  bsas_ram #(.W(32), .D(VD)) u_val (
    .clk(clk), .we(v_we), .waddr(v_waddr), .wdata(v_wdata),
    .raddr(v_raddr), .rdata(v_rdata)
  );

  // stack of pages given back by removed blocks
  bsas_ram #(.W(TI_W), .D(MAX_BLOCKS)) u_free (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .raddr(s_raddr), .rdata(s_rdata)
  );

  bsas_popcnt #(.MASK_BITS(MASK_BITS)) u_pc (
    .bits(pc_in), .count(pc_out)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:     if (accept) state_next = S_SR_RD;
      S_SR_RD:    state_next = (j == count) ? S_DISPATCH : S_SR_CHK;
      S_SR_CHK:   if (t_base >= key) state_next = S_DISPATCH;
                  else state_next = S_SR_RD;
      S_DISPATCH: begin
        unique case (act)
          ACT_GET: state_next = present ? S_GET_RD : S_FIN;
          ACT_SET: begin
            if (hit) state_next = S_SET;
            else if (count == CNT_W'(MAX_BLOCKS)) state_next = S_FIN;
            else state_next = S_ALLOC;
          end
          ACT_DEL: state_next = present ? S_DEL : S_FIN;
          default: state_next = S_FIN;
        endcase
      end
      S_GET_RD:   state_next = S_GET_WT;
      S_GET_WT:   state_next = S_FIN;
      S_ALLOC:    state_next = (free_top != '0) ? S_ALLOC_WT : S_TUP_CHK;
      S_ALLOC_WT: state_next = S_TUP_CHK;
      S_TUP_CHK:  state_next = (j == pos) ? S_SET : S_TUP_WR;
      S_TUP_WR:   state_next = S_TUP_CHK;
      S_SET:      state_next = pres[bitn] ? S_FIN : S_VUP_CHK;
      S_VUP_CHK:  state_next = (k == slot) ? S_FIN : S_VUP_WR;
      S_VUP_WR:   state_next = S_VUP_CHK;
      S_DEL:      state_next = (pc_out == PC_W'(1)) ? S_TDN_CHK : S_VDN_CHK;
      S_TDN_CHK:  state_next = (j == count) ? S_FIN : S_TDN_WR;
      S_TDN_WR:   state_next = S_TDN_CHK;
      S_VDN_CHK:  state_next = (k == cnt) ? S_FIN : S_VDN_WR;
      S_VDN_WR:   state_next = S_VDN_CHK;
      S_FIN:      if (out_free) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  always_comb begin
    t_we    = 1'b0;
    t_waddr = pos[TI_W-1:0];
    t_wdata = {key, pres, page};
    t_raddr = j[TI_W-1:0];
    v_we    = 1'b0;
    v_waddr = va(page, slot);
    v_wdata = val;
    v_raddr = va(page, slot);
    s_we    = 1'b0;
    s_waddr = free_top[TI_W-1:0];
    s_wdata = page;
    s_raddr = TI_W'(free_top - CNT_W'(1));
    pc_in   = pres;
    unique case (state)
      S_DISPATCH: pc_in = pres & below;
      S_TUP_CHK: begin
        if (j == pos) begin
          t_we    = 1'b1;
          t_wdata = {key, {MASK_BITS{1'b0}}, page};
        end else begin
          t_raddr = TI_W'(j - CNT_W'(1));
        end
      end
      S_TUP_WR: begin
        t_we    = 1'b1;
        t_waddr = j[TI_W-1:0];
        t_wdata = t_rdata;
      end
      S_SET: v_we = pres[bitn];
      S_VUP_CHK: begin
        if (k == slot) begin
          v_we    = 1'b1;
          t_we    = 1'b1;
          t_wdata = {key, pres | bm, page};
        end else begin
          v_raddr = va(page, k - PC_W'(1));
        end
      end
      S_VUP_WR: begin
        v_we    = 1'b1;
        v_waddr = va(page, k);
        v_wdata = v_rdata;
      end
      S_DEL: s_we = (pc_out == PC_W'(1));
      S_TDN_WR: begin
        t_we    = 1'b1;
        t_waddr = TI_W'(j - CNT_W'(1));
        t_wdata = t_rdata;
      end
      S_VDN_CHK: begin
        if (k == cnt) begin
          t_we    = 1'b1;
          t_wdata = {key, pres & ~bm, page};
        end else begin
          v_raddr = va(page, k);
        end
      end
      S_VDN_WR: begin
        v_we    = 1'b1;
        v_waddr = va(page, k - PC_W'(1));
        v_wdata = v_rdata;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      fresh     <= '0;
      free_top  <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && out_ready && state != S_FIN) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            act  <= action;
            key  <= in_key;
            bitn <= in_bit;
            val  <= value_in;
            j    <= '0;
            hit  <= 1'b0;
            st   <= ST_ABSENT;
            rval <= '0;
          end
        end
        S_SR_RD: if (j == count) pos <= j;
        S_SR_CHK: begin
          if (t_base == key) begin
            hit  <= 1'b1;
            pos  <= j;
            pres <= t_pres;
            page <= t_page;
          end else if (t_base > key) begin
            pos <= j;
          end else begin
            j <= j + CNT_W'(1);
          end
        end
        S_DISPATCH: begin
          slot <= pc_out;
          if (act == ACT_SET && !hit) begin
            j <= count;
            if (count == CNT_W'(MAX_BLOCKS)) st <= ST_FULL;
          end
        end
        S_GET_WT: begin
          st   <= ST_DONE;
          rval <= v_rdata;
        end
        S_ALLOC: begin
          if (free_top == '0) begin
            page  <= fresh[TI_W-1:0];
            fresh <= fresh + CNT_W'(1);
          end
        end
        S_ALLOC_WT: begin
          page     <= s_rdata;
          free_top <= free_top - CNT_W'(1);
        end
        S_TUP_CHK: begin
          if (j == pos) begin
            count <= count + CNT_W'(1);
            pres  <= '0;
            slot  <= '0;
          end
        end
        S_TUP_WR: j <= j - CNT_W'(1);
        S_SET: begin
          if (pres[bitn]) st <= ST_DONE;
          else k <= pc_out;
        end
        S_VUP_CHK: if (k == slot) st <= ST_DONE;
        S_VUP_WR: k <= k - PC_W'(1);
        S_DEL: begin
          if (pc_out == PC_W'(1)) begin
            free_top <= free_top + CNT_W'(1);
            j        <= pos + CNT_W'(1);
          end else begin
            k   <= slot + PC_W'(1);
            cnt <= pc_out;
          end
        end
        S_TDN_CHK: begin
          if (j == count) begin
            count <= count - CNT_W'(1);
            st    <= ST_DONE;
          end
        end
        S_TDN_WR: j <= j + CNT_W'(1);
        S_VDN_CHK: if (k == cnt) st <= ST_DONE;
        S_VDN_WR: k <= k + PC_W'(1);
        S_FIN: begin
          if (out_free) begin
            out_valid <= 1'b1;
            status    <= st;
            value_out <= rval;
          end
        end
        default: ;
      endcase
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_BLOCKS))
    else $error("block count above table size");

  a_page_pool: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> CNT_W'(fresh - free_top) == count)
    else $error("pages in use differ from block count");

  a_full_only_when_full: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && st == ST_FULL) |-> count == CNT_W'(MAX_BLOCKS))
    else $error("table full reported with free entries");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid && $stable(status) && $stable(value_out))
    else $error("pending result lost");

endmodule

### hdl/bsas_ram.sv
module bsas_ram
  import bsas_pkg::*;
#(
  parameter int W = 32,
  parameter int D = 64,
  localparam int AW = (D > 1) ? $clog2(D) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/bsas_popcnt.sv
module bsas_popcnt
  import bsas_pkg::*;
#(
  parameter int MASK_BITS = DEF_MASK_BITS,
  localparam int PC_W = $clog2(MASK_BITS + 1)
) (
  input  logic [MASK_BITS-1:0] bits,
  output logic [PC_W-1:0]      count
);

  localparam int NG = (MASK_BITS + 7) / 8;

  logic [3:0] part [NG];

  // groups of eight, then a sum over the groups
  always_comb begin
    for (int g = 0; g < NG; g++) begin
      part[g] = 4'd0;
      for (int b = 0; b < 8; b++) begin
        if (g * 8 + b < MASK_BITS) begin
          part[g] = part[g] + 4'(bits[g * 8 + b]);
        end
      end
    end
  end

  always_comb begin
    count = '0;
    for (int g = 0; g < NG; g++) begin
      count = count + PC_W'(part[g]);
    end
  end

endmodule
